// File: hw/rtl/srrf_pkg.sv
// srrf_pkg: types, codes and payload structs for the sequence-number keeper
// used by seqnum_resync_resend_fsm, srrf_decide and srrf_checker; no dependencies
package srrf_pkg;

    typedef enum logic [1:0] {
        MODE_SYNCED       = 2'd0,
        MODE_AWAIT_SYNC   = 2'd1,
        MODE_AWAIT_RESEND = 2'd2
    } t_mode;

    localparam logic [1:0] ACT_HEADER  = 2'd0;
    localparam logic [1:0] ACT_TIMEOUT = 2'd1;
    localparam logic [1:0] ACT_START   = 2'd2;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_RESEND  = 3'd1;
    localparam logic [2:0] KIND_REQUEST = 3'd2;
    localparam logic [2:0] KIND_SYNCREQ = 3'd3;
    localparam logic [2:0] KIND_RESYNC  = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] rx_seqnum;
        logic        flag_resend;
        logic        flag_request;
        logic        flag_syncreq;
        logic        flag_resync;
        logic        flag_master;
        logic        flag_valid;
        logic        buffer_hit;
    } t_in_item;

    typedef struct packed {
        logic        deliver;
        logic [2:0]  send_kind;
        logic [15:0] send_seqnum;
        logic        flush_buffer;
        logic        reset_app;
        logic        timer_start;
        logic        timer_stop;
        logic        seq_valid;
    } t_out_item;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] seq_counter;
        logic        valid_bit;
        logic [7:0]  missing_count;
        logic        timer_running;
    } t_state;

endpackage

// File: hw/rtl/srrf_decide.sv
// srrf_decide: combinational decision for one event, next state and result beat
// depends on srrf_pkg
module srrf_decide (
    input  srrf_pkg::t_state    i_state,
    input  logic                i_is_master,
    input  srrf_pkg::t_in_item  i_item,
    output srrf_pkg::t_state    o_state,
    output srrf_pkg::t_out_item o_res
);
    import srrf_pkg::*;

    logic [15:0] cur;
    logic [15:0] nxt;
    logic [15:0] d_rc;
    logic [15:0] d_rn;
    logic        ahead_rc;
    logic        ahead_rn;
    logic        m_resync;
    logic        resend_ok;
    logic [7:0]  miss_dec;
    t_out_item   res;
    t_state      ns;

    assign cur       = i_state.seq_counter;
    assign nxt       = cur + 16'd1;
    assign d_rc      = i_item.rx_seqnum - cur;
    assign d_rn      = i_item.rx_seqnum - nxt;
    assign ahead_rc  = (d_rc != 16'd0) && !d_rc[15];
    assign ahead_rn  = (d_rn != 16'd0) && !d_rn[15];
    assign m_resync  = i_item.flag_resync && i_item.flag_master;
    assign resend_ok = i_item.flag_resend && i_item.flag_valid && (nxt == i_item.rx_seqnum);
    assign miss_dec  = i_state.missing_count - 8'd1;

    // outputs
    always_comb begin
        res = '0;
        unique case (i_item.action) inside
            ACT_HEADER: begin
                unique case (i_state.mode)
                    MODE_SYNCED: begin
                        if (!i_item.flag_resend) begin
                            if (i_item.flag_request) begin
                                if ((i_is_master || i_state.valid_bit) && i_item.buffer_hit) begin
                                    res.send_kind   = KIND_RESEND;
                                    res.send_seqnum = i_item.rx_seqnum;
                                end
                            end else if (i_item.flag_syncreq) begin
                                if (i_is_master) begin
                                    res.send_kind   = KIND_RESYNC;
                                    res.send_seqnum = cur;
                                end
                            end else if (m_resync) begin
                                if (cur != i_item.rx_seqnum) begin
                                    res.flush_buffer = 1'b1;
                                    if (ahead_rc) begin
                                        res.send_kind   = KIND_REQUEST;
                                        res.send_seqnum = nxt;
                                    end else begin
                                        res.reset_app = 1'b1;
                                    end
                                end
                            end else if (i_item.flag_valid || i_item.flag_master) begin
                                if (nxt == i_item.rx_seqnum) begin
                                    res.deliver = 1'b1;
                                end else if (ahead_rn && i_item.flag_master) begin
                                    res.flush_buffer = 1'b1;
                                    res.send_kind    = KIND_REQUEST;
                                    res.send_seqnum  = nxt;
                                end else if (i_is_master) begin
                                    res.send_kind   = KIND_RESYNC;
                                    res.send_seqnum = cur;
                                end else begin
                                    res.send_kind   = KIND_SYNCREQ;
                                    res.send_seqnum = nxt;
                                end
                            end else if (i_is_master) begin
                                res.send_kind   = KIND_RESYNC;
                                res.send_seqnum = cur;
                            end
                        end
                    end
                    MODE_AWAIT_SYNC: begin
                        if (!m_resync && !i_item.flag_syncreq) begin
                            res.send_kind   = KIND_SYNCREQ;
                            res.send_seqnum = nxt;
                        end
                    end
                    MODE_AWAIT_RESEND: begin
                        if (resend_ok) begin
                            res.deliver    = 1'b1;
                            res.timer_stop = 1'b1;
                            if (miss_dec != 8'd0) begin
                                res.send_kind   = KIND_REQUEST;
                                res.send_seqnum = nxt + 16'd1;
                            end
                        end
                    end
                    default: begin
                        // unreachable mode: header dropped
                    end
                endcase
            end
            ACT_TIMEOUT, ACT_START: begin
                res.reset_app   = (i_item.action == ACT_TIMEOUT);
                res.send_seqnum = cur;
                if (i_is_master) begin
                    res.send_kind = KIND_RESYNC;
                end else begin
                    res.send_kind    = KIND_SYNCREQ;
                    res.flush_buffer = 1'b1;
                end
            end
            default: begin
                // unused action code: no effect
            end
        endcase
        // a stop in the same beat frees the timer for a fresh start
        res.timer_start = (res.send_kind == KIND_REQUEST) &&
                          (!i_state.timer_running || res.timer_stop);
    end

    // next state
    always_comb begin
        ns = i_state;
        unique case (i_item.action) inside
            ACT_HEADER: begin
                unique case (i_state.mode)
                    MODE_SYNCED: begin
                        if (!i_item.flag_resend && !i_item.flag_request &&
                            !i_item.flag_syncreq) begin
                            if (m_resync) begin
                                if (cur != i_item.rx_seqnum) begin
                                    if (ahead_rc) begin
                                        ns.missing_count = (d_rc[15:8] != 8'd0) ? 8'hFF
                                                                                 : d_rc[7:0];
                                        ns.valid_bit     = 1'b0;
                                        ns.mode          = MODE_AWAIT_RESEND;
                                    end else begin
                                        ns.seq_counter = i_item.rx_seqnum;
                                    end
                                end
                            end else if (i_item.flag_valid || i_item.flag_master) begin
                                if (nxt == i_item.rx_seqnum) begin
                                    ns.seq_counter = nxt;
                                end else if (ahead_rn && i_item.flag_master) begin
                                    ns.valid_bit = 1'b0;
                                    ns.mode      = MODE_AWAIT_RESEND;
                                end
                            end
                        end
                    end
                    MODE_AWAIT_SYNC: begin
                        if (m_resync) begin
                            ns.seq_counter = i_item.rx_seqnum;
                            ns.valid_bit   = 1'b1;
                            ns.mode        = MODE_SYNCED;
                        end else begin
                            ns.seq_counter = nxt;
                        end
                    end
                    MODE_AWAIT_RESEND: begin
                        if (resend_ok) begin
                            ns.seq_counter   = nxt;
                            ns.missing_count = miss_dec;
                            if (miss_dec == 8'd0) begin
                                ns.mode      = MODE_SYNCED;
                                ns.valid_bit = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ACT_TIMEOUT, ACT_START: begin
                if (i_is_master) begin
                    ns.mode = MODE_SYNCED;
                end else begin
                    ns.valid_bit = 1'b0;
                    ns.mode      = MODE_AWAIT_SYNC;
                end
            end
            default: begin
            end
        endcase
        ns.timer_running = res.timer_start ||
                           (i_state.timer_running && !res.timer_stop &&
                            (i_item.action != ACT_TIMEOUT));
    end

    assign o_state = ns;

    always_comb begin
        o_res           = res;
        o_res.seq_valid = i_is_master || ns.valid_bit;
    end

endmodule

// File: hw/rtl/seqnum_resync_resend_fsm.sv
// seqnum_resync_resend_fsm: receiver-side sequence-number keeper, top level
// depends on srrf_pkg and srrf_decide
//
//  channel  | direction | handshake                 | beat
//  ---------+-----------+---------------------------+-----------------------
//  in       | input     | i_in_valid / o_in_ready   | t_in_item (one event)
//  out      | output    | o_out_valid / i_out_ready | t_out_item (one result)
//  cfg      | input     | i_cfg_valid / o_cfg_ready | is_master bit
//
// one event per cycle while the result channel does not stall; each result beat passes
// the input register, then the result register, before it can be taken
// state is updated as an event leaves the input register, so events back to back
// see each other's effects; a stalled result register holds the input register
// reset: is_master 0, mode awaiting sync, counters and flags cleared
module seqnum_resync_resend_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  srrf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output srrf_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);
    import srrf_pkg::*;

    logic      r_is_master;
    t_state    r_state;
    t_state    n_state;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      out_free;
    logic      advance;

    srrf_decide u_decide (
        .i_state     (r_state),
        .i_is_master (r_is_master),
        .i_item      (r_in),
        .o_state     (n_state),
        .o_res       (n_out)
    );

    assign out_free    = !r_out_valid || i_out_ready;
    assign advance     = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_master <= 1'b0;
            r_state     <= '{mode: MODE_AWAIT_SYNC, seq_counter: 16'd0, valid_bit: 1'b0,
                             missing_count: 8'd0, timer_running: 1'b0};
        end else if (i_cfg_valid) begin
            // a register write sets the mode from the new bit: synced for a master, else awaiting sync
            r_is_master  <= i_cfg_data;
            r_state.mode <= i_cfg_data ? MODE_SYNCED : MODE_AWAIT_SYNC;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/srrf_checker.sv
// srrf_checker: port-level checks on seqnum_resync_resend_fsm, bound to the top
// depends on srrf_pkg
module srrf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input srrf_pkg::t_out_item o_out_item
);
    import srrf_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result beat changed while stalled");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.send_kind == KIND_NONE) |->
        (o_out_item.send_seqnum == 16'd0))
        else $error("seqnum set without a control packet");

    a_stop_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.timer_stop |-> o_out_item.deliver)
        else $error("timer stop without an accepted resend");

    a_start_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.timer_start |-> (o_out_item.send_kind == KIND_REQUEST))
        else $error("timer start without a request");

endmodule

bind seqnum_resync_resend_fsm srrf_checker u_srrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// File: sim/testbench.sv
// testbench for seqnum_resync_resend_fsm: drives header, timeout, link-start and unused-action beats,
// predicts each result in a scoreboard class and checks it field by field
// depends on srrf_pkg and the rtl of seqnum_resync_resend_fsm
`timescale 1ns / 100ps

module testbench;
    import srrf_pkg::*;

    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam int unsigned LIMIT = 300000;

    // header flag masks, order as in t_in_item
    localparam logic [6:0] F_RESEND  = 7'b1000000;
    localparam logic [6:0] F_REQUEST = 7'b0100000;
    localparam logic [6:0] F_SYNCREQ = 7'b0010000;
    localparam logic [6:0] F_RESYNC  = 7'b0001000;
    localparam logic [6:0] F_MASTER  = 7'b0000100;
    localparam logic [6:0] F_VALID   = 7'b0000010;
    localparam logic [6:0] F_HIT     = 7'b0000001;

    class seqnum_scoreboard;
        bit          master_node;
        t_mode       mode;
        logic [15:0] counter;
        bit          seq_ok;
        logic [7:0]  missing;
        bit          timer_on;
        t_out_item   res;
        t_out_item   due_results[$];
        int          errors;

        function new();
            master_node = 0;
            mode        = MODE_AWAIT_SYNC;
            counter     = '0;
            seq_ok      = 0;
            missing     = '0;
            timer_on    = 0;
            errors      = 0;
        endfunction

        function void note_master(bit m);
            master_node = m;
            mode        = m ? MODE_SYNCED : MODE_AWAIT_SYNC;
        endfunction

        // positive serial distance of a past ref, zero otherwise
        function logic [15:0] lead_over(logic [15:0] a, logic [15:0] ref_seq);
            logic [15:0] d;
            d = a - ref_seq;
            return (d != 0 && !d[15]) ? d : 16'd0;
        endfunction

        function void send_ctl(logic [2:0] kind, logic [15:0] seq);
            res.send_kind   = kind;
            res.send_seqnum = seq;
            if (kind == KIND_REQUEST && !timer_on) begin
                res.timer_start = 1'b1;
                timer_on        = 1;
            end
        endfunction

        function void start_sync();
            if (master_node) begin
                mode = MODE_SYNCED;
                send_ctl(KIND_RESYNC, counter);
            end else begin
                seq_ok           = 0;
                res.flush_buffer = 1'b1;
                mode             = MODE_AWAIT_SYNC;
                send_ctl(KIND_SYNCREQ, counter);
            end
        endfunction

        function void enter_resend(logic [15:0] nx);
            res.flush_buffer = 1'b1;
            seq_ok           = 0;
            mode             = MODE_AWAIT_RESEND;
            send_ctl(KIND_REQUEST, nx);
        endfunction

        function void take_header(t_in_item ev);
            logic [15:0] nx;
            logic [15:0] d;
            nx = counter + 16'd1;
            case (mode)
                MODE_SYNCED: begin
                    if (ev.flag_resend) return;
                    if (ev.flag_request) begin
                        if ((master_node || seq_ok) && ev.buffer_hit)
                            send_ctl(KIND_RESEND, ev.rx_seqnum);
                    end else if (ev.flag_syncreq) begin
                        if (master_node) send_ctl(KIND_RESYNC, counter);
                    end else if (ev.flag_resync && ev.flag_master) begin
                        if (counter == ev.rx_seqnum) return;
                        d = lead_over(ev.rx_seqnum, counter);
                        if (d != 0) begin
                            missing = (d > 16'd255) ? 8'hFF : d[7:0];
                            enter_resend(nx);
                        end else begin
                            res.flush_buffer = 1'b1;
                            res.reset_app    = 1'b1;
                            counter          = ev.rx_seqnum;
                        end
                    end else if (ev.flag_valid || ev.flag_master) begin
                        if (nx == ev.rx_seqnum) begin
                            counter     = nx;
                            res.deliver = 1'b1;
                        end else if (lead_over(ev.rx_seqnum, nx) != 0 && ev.flag_master) begin
                            // plain master packet ahead: missing count kept as is
                            enter_resend(nx);
                        end else if (master_node) begin
                            send_ctl(KIND_RESYNC, counter);
                        end else begin
                            send_ctl(KIND_SYNCREQ, nx);
                        end
                    end else if (master_node) begin
                        send_ctl(KIND_RESYNC, counter);
                    end
                end
                MODE_AWAIT_SYNC: begin
                    if (ev.flag_resync && ev.flag_master) begin
                        counter = ev.rx_seqnum;
                        seq_ok  = 1;
                        mode    = MODE_SYNCED;
                    end else begin
                        counter = nx;
                        if (!ev.flag_syncreq) send_ctl(KIND_SYNCREQ, nx);
                    end
                end
                MODE_AWAIT_RESEND: begin
                    if (ev.flag_resend && ev.flag_valid && nx == ev.rx_seqnum) begin
                        counter        = nx;
                        missing        = missing - 8'd1;
                        res.timer_stop = 1'b1;
                        timer_on       = 0;
                        if (missing != 0) begin
                            send_ctl(KIND_REQUEST, nx + 16'd1);
                        end else begin
                            mode   = MODE_SYNCED;
                            seq_ok = 1;
                        end
                        res.deliver = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_event(t_in_item ev);
            res = '0;
            case (ev.action)
                ACT_HEADER: take_header(ev);
                ACT_TIMEOUT: begin
                    timer_on      = 0;
                    res.reset_app = 1'b1;
                    start_sync();
                end
                ACT_START: start_sync();
                default: ;
            endcase
            res.seq_valid = master_node || seq_ok;
            due_results.push_back(res);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, actual %h", $time, got);
                return;
            end
            want = due_results.pop_front();
            compare("deliver", 16'(want.deliver), 16'(got.deliver));
            compare("send_kind", 16'(want.send_kind), 16'(got.send_kind));
            compare("send_seqnum", want.send_seqnum, got.send_seqnum);
            compare("flush_buffer", 16'(want.flush_buffer), 16'(got.flush_buffer));
            compare("reset_app", 16'(want.reset_app), 16'(got.reset_app));
            compare("timer_start", 16'(want.timer_start), 16'(got.timer_start));
            compare("timer_stop", 16'(want.timer_stop), 16'(got.timer_stop));
            compare("seq_valid", 16'(want.seq_valid), 16'(got.seq_valid));
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_data = 1'b0;

    seqnum_scoreboard ledger = new();
    int unsigned cycles = 0;
    int idle_in = 23;
    int idle_out = 55;

    seqnum_resync_resend_fsm i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // receiver: random stall, result check on every accepted beat
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= idle_out);
        if (i_rst_n && o_out_valid && i_out_ready) ledger.check_result(o_out_item);
    end

    function automatic t_in_item make_ev(logic [1:0] act, logic [15:0] rx, logic [6:0] fl);
        t_in_item ev;
        ev = {act, rx, fl};
        return ev;
    endfunction

    task automatic send_event(t_in_item ev);
        while ($urandom_range(99) < idle_in) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= ev;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        ledger.note_event(ev);
    endtask

    // stop sending and let every outstanding result drain
    task automatic settle();
        i_in_valid <= 1'b0;
        while (ledger.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_master(bit m);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        ledger.note_master(m);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly well-formed traffic for the current mode, the rest noise
    function automatic t_in_item random_event();
        int pick;
        logic [15:0] c;
        logic [15:0] nx;
        logic [6:0] extra;
        pick  = $urandom_range(99);
        c     = ledger.counter;
        nx    = c + 16'd1;
        extra = 7'($urandom);
        if (pick < 10) return make_ev(2'($urandom), 16'($urandom), extra);
        if (pick < 13) return make_ev(ACT_TIMEOUT, 16'($urandom), extra);
        if (pick < 16) return make_ev(ACT_START, 16'($urandom), extra);
        case (ledger.mode)
            MODE_AWAIT_SYNC: begin
                if (pick < 60)
                    return make_ev(ACT_HEADER, 16'($urandom),
                                   F_RESYNC | F_MASTER | (extra & (F_VALID | F_HIT)));
                return make_ev(ACT_HEADER, 16'($urandom), extra & ~F_RESYNC);
            end
            MODE_SYNCED: begin
                if (pick < 55)
                    return make_ev(ACT_HEADER, nx, F_VALID | (extra & (F_MASTER | F_HIT)));
                if (pick < 62)
                    return make_ev(ACT_HEADER, 16'(nx + $urandom_range(1, 6)),
                                   F_MASTER | (extra & F_VALID));
                if (pick < 70) begin
                    if ($urandom_range(19) == 0)
                        return make_ev(ACT_HEADER, 16'(c + $urandom_range(256, 16'h7FFF)),
                                       F_RESYNC | F_MASTER);
                    return make_ev(ACT_HEADER, 16'(c + $urandom_range(8) - 4),
                                   F_RESYNC | F_MASTER | (extra & F_VALID));
                end
                if (pick < 79)
                    return make_ev(ACT_HEADER, 16'($urandom),
                                   F_REQUEST | (extra & (F_HIT | F_VALID | F_MASTER)));
                if (pick < 84)
                    return make_ev(ACT_HEADER, 16'($urandom), F_SYNCREQ | (extra & F_VALID));
                if (pick < 92)
                    return make_ev(ACT_HEADER, 16'(nx + $urandom_range(6) - 3), F_VALID);
                return make_ev(ACT_HEADER, 16'($urandom), extra);
            end
            MODE_AWAIT_RESEND: begin
                if (pick < 88)
                    return make_ev(ACT_HEADER, nx, F_RESEND | F_VALID | (extra & F_HIT));
                if (pick < 93)
                    return make_ev(ACT_HEADER, 16'(nx + 1), F_RESEND | F_VALID);
                return make_ev(ACT_HEADER, 16'($urandom), extra);
            end
            default: return make_ev(2'($urandom), 16'($urandom), extra);
        endcase
    endfunction

    task automatic run_phase(int in_pct, int out_pct, bit m, int count);
        write_master(m);
        idle_in  = in_pct;
        idle_out = out_pct;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) settle();
            send_event(random_event());
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // slave walk: sync, wrap, request, resync cases, resend chain, expiry
        write_master(1'b0);
        send_event(make_ev(ACT_IGNORED, 16'hFFFF, 7'h7F));
        send_event(make_ev(ACT_HEADER, 16'h0000, 7'h00));
        send_event(make_ev(ACT_HEADER, 16'h0000, F_SYNCREQ));
        send_event(make_ev(ACT_HEADER, 16'hFFFF, F_RESYNC | F_MASTER));
        send_event(make_ev(ACT_HEADER, 16'h0000, F_VALID));
        send_event(make_ev(ACT_HEADER, 16'h1234, F_REQUEST | F_HIT));
        send_event(make_ev(ACT_HEADER, 16'h0000, F_SYNCREQ));
        send_event(make_ev(ACT_HEADER, 16'h0001, F_RESEND));
        send_event(make_ev(ACT_HEADER, 16'h0001, 7'h00));
        send_event(make_ev(ACT_HEADER, ledger.counter, F_VALID));
        send_event(make_ev(ACT_HEADER, 16'(ledger.counter + 6), F_VALID));
        send_event(make_ev(ACT_HEADER, ledger.counter, F_RESYNC | F_MASTER));
        send_event(make_ev(ACT_HEADER, 16'(ledger.counter - 2), F_RESYNC | F_MASTER));
        send_event(make_ev(ACT_HEADER, 16'(ledger.counter + 3), F_RESYNC | F_MASTER));
        send_event(make_ev(ACT_HEADER, 16'(ledger.counter + 2), F_RESEND | F_VALID));
        repeat (3)
            send_event(make_ev(ACT_HEADER, 16'(ledger.counter + 1), F_RESEND | F_VALID));
        send_event(make_ev(ACT_HEADER, 16'(ledger.counter + 16'h4000), F_RESYNC | F_MASTER));
        send_event(make_ev(ACT_TIMEOUT, 16'h0000, 7'h00));
        send_event(make_ev(ACT_START, 16'h0000, 7'h00));
        send_event(make_ev(ACT_HEADER, 16'h8000, F_RESYNC | F_MASTER));

        // master side answers
        write_master(1'b1);
        send_event(make_ev(ACT_HEADER, 16'h0000, F_SYNCREQ));
        send_event(make_ev(ACT_HEADER, 16'h0000, 7'h00));
        send_event(make_ev(ACT_HEADER, ledger.counter, F_VALID));
        send_event(make_ev(ACT_HEADER, 16'(ledger.counter + 3), F_VALID));
        send_event(make_ev(ACT_TIMEOUT, 16'hFFFF, 7'h7F));

        run_phase(23, 55, 1'b0, 100);
        run_phase(23, 55, 1'b1, 100);
        run_phase(55, 23, 1'b1, 100);
        run_phase(55, 23, 1'b0, 100);
        run_phase(0, 0, 1'b1, 100);
        run_phase(0, 0, 1'b0, 100);

        settle();
        if (ledger.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/srrf_pkg.sv
hw/rtl/srrf_decide.sv
hw/rtl/seqnum_resync_resend_fsm.sv
hw/rtl/srrf_checker.sv
sim/testbench.sv
